[rtl/core/co2fp_pkg.sv]
// co2fp_pkg: shared types, constants and the BCD-style byte conversion
// for the CO2 sensor frame parser. No dependencies.

package co2fp_pkg;

    localparam int BYTE_W   = 8;
    localparam int WEIGHT_W = 11;
    localparam int PPM_W    = 18;
    localparam int POS_W    = 4;

    localparam logic [BYTE_W-1:0]   FRAME_START  = 8'hFF;
    localparam logic [BYTE_W-1:0]   FRAME_CMD    = 8'h86;
    localparam logic [POS_W-1:0]    POS_CMD      = 4'd2;
    localparam logic [POS_W-1:0]    POS_HIGH     = 4'd2;
    localparam logic [POS_W-1:0]    POS_LOW      = 4'd3;
    localparam logic [POS_W-1:0]    POS_CHECK    = 4'd8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 11'd1024;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 11'd256;

    // Divide-by-ten reciprocal: (x * 205) >> 11 is exact for all 8-bit x
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEAD,
        PH_BODY
    } phase_t;

    // Frame tracker status handed to the result stage
    typedef struct packed {
        logic              last;     // accepted beat is the checksum byte
        logic              sum_ok;   // checksum byte plus running sum is zero
        logic [BYTE_W-1:0] conv_hi;  // converted high concentration byte
        logic [BYTE_W-1:0] conv_lo;  // converted low concentration byte
    } frame_stat_t;

    // conv(x) = ((x / 10) * 16 + x % 10) mod 256
    function automatic logic [BYTE_W-1:0] conv_byte(input logic [BYTE_W-1:0] x);
        logic [15:0] prod;
        logic [4:0]  quo;
        logic [8:0]  tens;
        logic [3:0]  rem;
        logic [8:0]  full;
        prod = 16'(x) * 16'(DIV10_MUL);
        quo  = 5'(prod >> DIV10_SHIFT);
        tens = 9'(quo) * 9'd10;
        rem  = 4'(9'(x) - tens);
        full = {quo, 4'b0000} + 9'(rem);
        return full[BYTE_W-1:0];
    endfunction

endpackage

[rtl/core/co2fp_if.sv]
// co2fp_if: valid/ready channel interfaces for received bytes and results.
// Depends on co2fp_pkg for field widths.

interface co2fp_byte_if
    import co2fp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface co2fp_result_if
    import co2fp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PPM_W-1:0] concentration_ppm;
    logic             checksum_good;

    modport source (output valid, output concentration_ppm, output checksum_good,
                    input ready);
    modport sink   (input valid, input concentration_ppm, input checksum_good,
                    output ready);
endinterface

[rtl/core/co2_sensor_frame_parser.sv]
// co2_sensor_frame_parser: top level of the nine-byte CO2 frame parser.
// The result is registered: valid in the cycle after the checksum byte's beat.
// Throughput: one byte per cycle; input stalls only while a result waits
// in the single output register.
// Reset (rst_n, async low): hunting, sums and bytes cleared, weight = 256.
// Depends on co2fp_pkg, co2fp_if, co2fp_tracker, co2fp_result.

module co2_sensor_frame_parser
    import co2fp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [WEIGHT_W-1:0] cfg_wdata,
    co2fp_byte_if.sink          rx,
    co2fp_result_if.source      res
);

    logic        can_take;
    logic        beat;
    frame_stat_t stat;

    assign rx.ready = can_take;
    assign beat     = rx.valid && can_take;

    // Frame tracking
    co2fp_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .rx_byte (rx.rx_byte),
        .stat    (stat)
    );

    // Result arithmetic and output register
    co2fp_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .beat      (beat),
        .stat      (stat),
        .can_take  (can_take),
        .res       (res)
    );

endmodule

[rtl/core/co2fp_tracker.sv]
// co2fp_tracker: frame hunt state machine, running checksum and captured
// concentration bytes. Depends on co2fp_pkg.

module co2fp_tracker
    import co2fp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,      // byte accepted this cycle
    input  logic [BYTE_W-1:0] rx_byte,
    output frame_stat_t       stat
);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]   conv_hi_reg, conv_hi_next;
    logic [BYTE_W-1:0]   conv_lo_reg, conv_lo_next;
    logic [BYTE_W-1:0]   conv_in;
    logic [BYTE_W-1:0]   sum_add;

    assign conv_in = conv_byte(rx_byte);
    assign sum_add = sum_reg + rx_byte;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            pos_reg     <= '0;
            sum_reg     <= '0;
            conv_hi_reg <= '0;
            conv_lo_reg <= '0;
        end
        else if (beat)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            conv_hi_reg <= conv_hi_next;
            conv_lo_reg <= conv_lo_next;
        end
    end

    // Next state and frame status
    always_comb
    begin
        phase_next   = PH_HUNT;
        pos_next     = '0;
        sum_next     = sum_reg;
        conv_hi_next = conv_hi_reg;
        conv_lo_next = conv_lo_reg;
        stat.last    = 1'b0;
        stat.sum_ok  = (sum_add == '0);
        stat.conv_hi = conv_hi_reg;
        stat.conv_lo = conv_lo_reg;
        case (phase_reg)
            PH_HEAD:
            begin
                // bad second byte drops back to hunting, not rechecked as start
                if (rx_byte == FRAME_CMD)
                begin
                    phase_next = PH_BODY;
                    pos_next   = POS_CMD;
                    sum_next   = rx_byte;
                end
            end
            PH_BODY:
            begin
                if (pos_reg >= POS_CHECK)
                begin
                    stat.last = 1'b1;
                    sum_next  = '0;
                end
                else
                begin
                    phase_next = PH_BODY;
                    pos_next   = pos_reg + POS_W'(1);
                    sum_next   = sum_add;
                    if (pos_reg == POS_HIGH)
                        conv_hi_next = conv_in;
                    else if (pos_reg == POS_LOW)
                        conv_lo_next = conv_in;
                end
            end
            default:
            begin
                if (rx_byte == FRAME_START)
                begin
                    phase_next = PH_HEAD;
                    pos_next   = POS_W'(1);
                end
            end
        endcase
    end

endmodule

[rtl/core/co2fp_result.sv]
// co2fp_result: weight register, concentration arithmetic and the output
// register of the result channel. Depends on co2fp_pkg and co2fp_if.

module co2fp_result
    import co2fp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [WEIGHT_W-1:0] cfg_wdata,
    input  logic                beat,
    input  frame_stat_t         stat,
    output logic                can_take,   // output register free for a new beat
    co2fp_result_if.source      res
);

    logic [WEIGHT_W-1:0] weight_reg;
    logic                valid_reg;
    logic [PPM_W-1:0]    ppm_reg;
    logic                good_reg;
    logic [BYTE_W+WEIGHT_W-1:0] prod;
    logic [PPM_W-1:0]    ppm_calc;

    // Weight register, clamped on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= WEIGHT_RESET;
        else if (cfg_we)
            weight_reg <= (cfg_wdata > WEIGHT_MAX) ? WEIGHT_MAX : cfg_wdata;
    end

    // One 8x11 product plus the low byte
    assign prod     = (BYTE_W+WEIGHT_W)'(stat.conv_hi) * (BYTE_W+WEIGHT_W)'(weight_reg);
    assign ppm_calc = PPM_W'(prod + (BYTE_W+WEIGHT_W)'(stat.conv_lo));

    assign can_take = !valid_reg || res.ready;

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_take)
            valid_reg <= beat && stat.last;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (can_take && beat && stat.last)
        begin
            ppm_reg  <= ppm_calc;
            good_reg <= stat.sum_ok;
        end
    end

    assign res.valid             = valid_reg;
    assign res.concentration_ppm = ppm_reg;
    assign res.checksum_good     = good_reg;

endmodule
